[sv/two_class_weighted_round_robin_picker_core_macros.svh]
// Assertion macros for the two-class weighted round-robin picker.
// Used by two_class_weighted_round_robin_picker_core.sv; expects clk and rst_n in scope.
`ifndef TWO_CLASS_WEIGHTED_ROUND_ROBIN_PICKER_CORE_MACROS_SVH
`define TWO_CLASS_WEIGHTED_ROUND_ROBIN_PICKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside of reset.
`define TWRR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TWRR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define TWRR_ASSERT(lbl, prop, msg)
`define TWRR_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

[sv/twrr_pkg.sv]
// Shared types and constants of the two-class weighted round-robin picker.
// No dependencies; used by twrr_mod_unit and the top level.
`timescale 1ns / 1ps

package twrr_pkg;

    localparam int PTR_W     = 6;   // round-robin pointer width
    localparam int CNT_W     = 7;   // per-class runnable count (up to 64)
    localparam int SLOT_W    = 6;   // granted slot index width
    localparam int GRANT_W   = 32;  // saturating grant counters
    localparam int WEIGHT_W  = 8;
    localparam int STEP_W    = 3;   // remainder unit step counter
    localparam int TRIAL_W   = CNT_W + PTR_W - 1;
    localparam int LIMIT_W   = WEIGHT_W + GRANT_W;
    localparam int MASK_W    = 64;  // width of each mask field on the input

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd9;
    localparam logic [GRANT_W-1:0]  GRANT_MAX    = '1;

    typedef struct packed {
        logic             done;
        logic [PTR_W-1:0] rem;
    } mod_rsp_t;

endpackage

[sv/twrr_mod_unit.sv]
// Iterative remainder unit: pointer mod count, one restoring step per cycle.
// Depends on twrr_pkg.
`timescale 1ns / 1ps

module twrr_mod_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [twrr_pkg::PTR_W-1:0]   dividend,
    input  logic [twrr_pkg::CNT_W-1:0]   divisor,
    output twrr_pkg::mod_rsp_t           rsp
);

    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [twrr_pkg::STEP_W-1:0]   step_reg;
    logic [twrr_pkg::STEP_W-1:0]   step_next;
    logic [twrr_pkg::PTR_W-1:0]    rem_reg;
    logic [twrr_pkg::PTR_W-1:0]    rem_next;
    logic [twrr_pkg::CNT_W-1:0]    div_reg;
    logic [twrr_pkg::CNT_W-1:0]    div_next;
    logic [twrr_pkg::TRIAL_W-1:0]  trial;

    // divisor shifted to the weight of the current quotient bit
    assign trial = twrr_pkg::TRIAL_W'(div_reg) << step_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = twrr_pkg::STEP_W'(twrr_pkg::PTR_W - 1);
            rem_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (twrr_pkg::TRIAL_W'(rem_reg) >= trial)
            begin
                rem_next = rem_reg - trial[twrr_pkg::PTR_W-1:0];
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - twrr_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

[sv/two_class_weighted_round_robin_picker_core.sv]
// Each round runs a one-slot-per-cycle mask scan to count the classes, the 6-step
// remainder unit on the winning pointer and a second scan to the chosen slot; when nothing
// is runnable, the remainder unit and the second scan are skipped.
// Throughput: one scheduling round at a time; the next input is taken in the cycle after the
// result is loaded into the output register, even while that result still waits.
// Reset (rst_n, async, active low): pointers and grant counters clear, weight 9, no result.
`timescale 1ns / 1ps
`include "two_class_weighted_round_robin_picker_core_macros.svh"

module two_class_weighted_round_robin_picker_core
#(
    parameter int SLOTS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration: fg_weight
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    // input round
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] runnable_mask, [127:64] background_mask
    // result
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // [0] grant_valid, [6:1] grant_slot, [7] zero
    output logic         m_axis_tuser    // [0] grant_background
);

    localparam int IDX_W = $clog2(SLOTS);

    typedef enum logic [6:0]
    {
        ST_IDLE   = 7'b0000001,
        ST_COUNT  = 7'b0000010,
        ST_MULT   = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_MODW   = 7'b0010000,
        ST_SELECT = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    // control state
    state_t                              state_reg, state_next;
    logic [IDX_W-1:0]                    idx_reg, idx_next;
    logic [twrr_pkg::CNT_W-1:0]          fg_cnt_reg, fg_cnt_next;
    logic [twrr_pkg::CNT_W-1:0]          bg_cnt_reg, bg_cnt_next;
    logic [twrr_pkg::PTR_W-1:0]          seen_reg, seen_next;
    logic [twrr_pkg::PTR_W-1:0]          fg_pointer_reg, fg_pointer_next;
    logic [twrr_pkg::PTR_W-1:0]          bg_pointer_reg, bg_pointer_next;
    logic [twrr_pkg::GRANT_W-1:0]        fg_grants_reg, fg_grants_next;
    logic [twrr_pkg::GRANT_W-1:0]        bg_grants_reg, bg_grants_next;
    logic [twrr_pkg::WEIGHT_W-1:0]       weight_reg, weight_next;
    logic                                m_tvalid_reg, m_tvalid_next;

    // payload
    logic [SLOTS-1:0]                    run_reg, run_next;
    logic [SLOTS-1:0]                    bgm_reg, bgm_next;
    logic [twrr_pkg::LIMIT_W-1:0]        limit_reg, limit_next;
    logic                                cls_bg_reg, cls_bg_next;
    logic [twrr_pkg::CNT_W-1:0]          sel_cnt_reg, sel_cnt_next;
    logic [twrr_pkg::PTR_W-1:0]          pos_reg, pos_next;
    logic                                res_valid_reg, res_valid_next;
    logic [twrr_pkg::SLOT_W-1:0]         res_slot_reg, res_slot_next;
    logic                                res_bg_reg, res_bg_next;
    logic [twrr_pkg::SLOT_W-1:0]         out_slot_reg, out_slot_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                out_bg_reg, out_bg_next;

    // datapath helpers
    logic                                fg_wins;
    logic                                mod_start;
    logic [twrr_pkg::PTR_W-1:0]          mod_dividend;
    logic [twrr_pkg::CNT_W-1:0]          mod_divisor;
    twrr_pkg::mod_rsp_t                  mod_rsp;
    logic                                slot_hit;
    logic [twrr_pkg::CNT_W-1:0]          pos_inc;
    logic [twrr_pkg::PTR_W-1:0]          ptr_wrap;
    logic                                out_free;

    // Foreground wins when it has entries and either background is empty, it is still
    // under its first weight worth of grants, or it trails weight times the background grants.
    assign fg_wins = (fg_cnt_reg != '0) &&
                     ((bg_cnt_reg == '0) ||
                      (fg_grants_reg < twrr_pkg::GRANT_W'(weight_reg)) ||
                      (twrr_pkg::LIMIT_W'(fg_grants_reg) < limit_reg));

    // Remainder unit takes the winning class's pointer and runnable count.
    assign mod_start    = (state_reg == ST_DECIDE) &&
                          ((fg_cnt_reg != '0) || (bg_cnt_reg != '0));
    assign mod_dividend = fg_wins ? fg_pointer_reg : bg_pointer_reg;
    assign mod_divisor  = fg_wins ? fg_cnt_reg : bg_cnt_reg;

    twrr_mod_unit u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .rsp      (mod_rsp)
    );

    // Slot under the scan belongs to the winning class and is runnable.
    assign slot_hit = run_reg[idx_reg] && (bgm_reg[idx_reg] == cls_bg_reg);

    // Advance the class pointer, wrapping at the class count.
    assign pos_inc  = twrr_pkg::CNT_W'(pos_reg) + twrr_pkg::CNT_W'(1);
    assign ptr_wrap = (pos_inc == sel_cnt_reg) ? '0 : pos_inc[twrr_pkg::PTR_W-1:0];

    // Output register can take a new result when empty or being drained.
    assign out_free = !m_tvalid_reg || m_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        fg_cnt_next     = fg_cnt_reg;
        bg_cnt_next     = bg_cnt_reg;
        seen_next       = seen_reg;
        fg_pointer_next = fg_pointer_reg;
        bg_pointer_next = bg_pointer_reg;
        fg_grants_next  = fg_grants_reg;
        bg_grants_next  = bg_grants_reg;
        weight_next     = weight_reg;
        m_tvalid_next   = m_tvalid_reg;
        run_next        = run_reg;
        bgm_next        = bgm_reg;
        limit_next      = limit_reg;
        cls_bg_next     = cls_bg_reg;
        sel_cnt_next    = sel_cnt_reg;
        pos_next        = pos_reg;
        res_valid_next  = res_valid_reg;
        res_slot_next   = res_slot_reg;
        res_bg_next     = res_bg_reg;
        out_slot_next   = out_slot_reg;
        out_valid_next  = out_valid_reg;
        out_bg_next     = out_bg_reg;

        // configuration write lands at any time; hold otherwise
        if (cfg_we)
        begin
            weight_next = cfg_wdata;
        end

        // drop the pending result once the downstream takes it
        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    run_next    = s_axis_tdata[SLOTS-1:0];
                    bgm_next    = s_axis_tdata[twrr_pkg::MASK_W +: SLOTS];
                    idx_next    = '0;
                    fg_cnt_next = '0;
                    bg_cnt_next = '0;
                    state_next  = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                // one slot per cycle into the class counters
                if (run_reg[idx_reg])
                begin
                    if (bgm_reg[idx_reg])
                    begin
                        bg_cnt_next = bg_cnt_reg + twrr_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        fg_cnt_next = fg_cnt_reg + twrr_pkg::CNT_W'(1);
                    end
                end
                if (idx_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = ST_MULT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_MULT:
            begin
                limit_next = twrr_pkg::LIMIT_W'(weight_reg) * twrr_pkg::LIMIT_W'(bg_grants_reg);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                res_valid_next = 1'b0;
                res_slot_next  = '0;
                res_bg_next    = 1'b0;
                cls_bg_next    = !fg_wins;
                sel_cnt_next   = mod_divisor;
                if (mod_start)
                begin
                    state_next = ST_MODW;
                end
                else
                begin
                    // nothing runnable: empty result, no state change
                    state_next = ST_FINISH;
                end
            end
            ST_MODW:
            begin
                if (mod_rsp.done)
                begin
                    pos_next   = mod_rsp.rem;
                    idx_next   = '0;
                    seen_next  = '0;
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                // walk to the pos-th runnable slot of the winning class
                if (slot_hit && (seen_reg == pos_reg))
                begin
                    res_valid_next = 1'b1;
                    res_slot_next  = twrr_pkg::SLOT_W'(idx_reg);
                    res_bg_next    = cls_bg_reg;
                    if (cls_bg_reg)
                    begin
                        bg_pointer_next = ptr_wrap;
                        if (bg_grants_reg != twrr_pkg::GRANT_MAX)
                        begin
                            bg_grants_next = bg_grants_reg + twrr_pkg::GRANT_W'(1);
                        end
                    end
                    else
                    begin
                        fg_pointer_next = ptr_wrap;
                        if (fg_grants_reg != twrr_pkg::GRANT_MAX)
                        begin
                            fg_grants_next = fg_grants_reg + twrr_pkg::GRANT_W'(1);
                        end
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (slot_hit)
                    begin
                        seen_next = seen_reg + twrr_pkg::PTR_W'(1);
                    end
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    out_valid_next = res_valid_reg;
                    out_slot_next  = res_slot_reg;
                    out_bg_next    = res_bg_reg;
                    m_tvalid_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            fg_cnt_reg     <= '0;
            bg_cnt_reg     <= '0;
            seen_reg       <= '0;
            fg_pointer_reg <= '0;
            bg_pointer_reg <= '0;
            fg_grants_reg  <= '0;
            bg_grants_reg  <= '0;
            weight_reg     <= twrr_pkg::WEIGHT_RESET;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            fg_cnt_reg     <= fg_cnt_next;
            bg_cnt_reg     <= bg_cnt_next;
            seen_reg       <= seen_next;
            fg_pointer_reg <= fg_pointer_next;
            bg_pointer_reg <= bg_pointer_next;
            fg_grants_reg  <= fg_grants_next;
            bg_grants_reg  <= bg_grants_next;
            weight_reg     <= weight_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg       <= run_next;
        bgm_reg       <= bgm_next;
        limit_reg     <= limit_next;
        cls_bg_reg    <= cls_bg_next;
        sel_cnt_reg   <= sel_cnt_next;
        pos_reg       <= pos_next;
        res_valid_reg <= res_valid_next;
        res_slot_reg  <= res_slot_next;
        res_bg_reg    <= res_bg_next;
        out_valid_reg <= out_valid_next;
        out_slot_reg  <= out_slot_next;
        out_bg_reg    <= out_bg_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {1'b0, out_slot_reg, out_valid_reg};
    assign m_axis_tuser  = out_bg_reg;

    // an empty grant carries a zero slot and the foreground class
    `TWRR_ASSERT_IMPLY(a_empty_grant_zero, m_axis_tvalid && !m_axis_tdata[0], (m_axis_tdata[6:1] == '0) && !m_axis_tuser, "empty grant with nonzero slot or class")
    // the selection scan never runs past the target position
    `TWRR_ASSERT_IMPLY(a_scan_bound, state_reg == ST_SELECT, seen_reg <= pos_reg, "selection scan passed its target")
    // remainder is always below the class count
    `TWRR_ASSERT_IMPLY(a_rem_bound, mod_rsp.done, twrr_pkg::CNT_W'(mod_rsp.rem) < sel_cnt_reg, "remainder not below class count")
    // grant counters move by at most one per cycle
    `TWRR_ASSERT(a_fg_step, 1'b1 |=> ((fg_grants_reg == $past(fg_grants_reg)) || (fg_grants_reg == $past(fg_grants_reg) + 32'd1)), "foreground grant counter jumped")
    `TWRR_ASSERT(a_bg_step, 1'b1 |=> ((bg_grants_reg == $past(bg_grants_reg)) || (bg_grants_reg == $past(bg_grants_reg) + 32'd1)), "background grant counter jumped")

endmodule

[sim/twrr_grant_checker.sv]
// Scoreboard for the two-class weighted round-robin picker: watches the config,
// input and result channels, predicts each grant and compares it. Depends on twrr_pkg.
`timescale 1ns / 1ps

module twrr_grant_checker
#(
    parameter int SLOTS = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [twrr_pkg::WEIGHT_W-1:0] cfg_wdata,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [127:0]                  s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [7:0]                    m_axis_tdata,
    input  logic                          m_axis_tuser,
    output int                            errors,
    output int                            pending
);

    typedef struct packed {
        logic                        valid;
        logic [twrr_pkg::SLOT_W-1:0] slot;
        logic                        bg;
    } grant_t;

    localparam logic [twrr_pkg::MASK_W-1:0] SLOT_MASK =
        {twrr_pkg::MASK_W{1'b1}} >> (twrr_pkg::MASK_W - SLOTS);

    grant_t                        grant_q[$];
    int                            mismatch_count;
    logic [twrr_pkg::WEIGHT_W-1:0] weight;
    logic [twrr_pkg::PTR_W-1:0]    fg_ptr;
    logic [twrr_pkg::PTR_W-1:0]    bg_ptr;
    logic [twrr_pkg::GRANT_W-1:0]  fg_grants;
    logic [twrr_pkg::GRANT_W-1:0]  bg_grants;

    // Slot index of the n-th set bit, counting from the lowest slot.
    function automatic int nth_slot(input logic [twrr_pkg::MASK_W-1:0] m, input int n);
        int seen;
        seen = 0;
        for (int i = 0; i < twrr_pkg::MASK_W; i++)
        begin
            if (m[i])
            begin
                if (seen == n)
                    return i;
                seen++;
            end
        end
        return 0;
    endfunction

    // Pick the winner of one round and advance the class pointer and grant counter.
    function automatic grant_t pick_slot(input logic [twrr_pkg::MASK_W-1:0] runnable,
                                         input logic [twrr_pkg::MASK_W-1:0] background);
        logic [twrr_pkg::MASK_W-1:0]  fg_set;
        logic [twrr_pkg::MASK_W-1:0]  bg_set;
        logic [twrr_pkg::LIMIT_W-1:0] fg_limit;
        int                           fg_n;
        int                           bg_n;
        grant_t                       g;
        fg_set   = runnable & SLOT_MASK & ~background;
        bg_set   = runnable & SLOT_MASK & background;
        fg_n     = $countones(fg_set);
        bg_n     = $countones(bg_set);
        fg_limit = twrr_pkg::LIMIT_W'(weight) * twrr_pkg::LIMIT_W'(bg_grants);
        g        = '0;
        if (fg_n > 0 && (bg_n == 0 || fg_grants < twrr_pkg::GRANT_W'(weight)
                         || twrr_pkg::LIMIT_W'(fg_grants) < fg_limit))
        begin
            g.valid = 1'b1;
            g.slot  = twrr_pkg::SLOT_W'(nth_slot(fg_set, int'(fg_ptr) % fg_n));
            fg_ptr  = twrr_pkg::PTR_W'((int'(fg_ptr) + 1) % fg_n);
            if (fg_grants != twrr_pkg::GRANT_MAX)
                fg_grants = fg_grants + twrr_pkg::GRANT_W'(1);
        end
        else if (bg_n > 0)
        begin
            g.valid = 1'b1;
            g.bg    = 1'b1;
            g.slot  = twrr_pkg::SLOT_W'(nth_slot(bg_set, int'(bg_ptr) % bg_n));
            bg_ptr  = twrr_pkg::PTR_W'((int'(bg_ptr) + 1) % bg_n);
            if (bg_grants != twrr_pkg::GRANT_MAX)
                bg_grants = bg_grants + twrr_pkg::GRANT_W'(1);
        end
        return g;
    endfunction

    task automatic report(input string field, input int want, input int seen);
        $display("%0t: grant mismatch on %s: expected %0d, actual %0d",
                 $time, field, want, seen);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        grant_t got;
        grant_t want;
        if (!rst_n)
        begin
            weight         = twrr_pkg::WEIGHT_RESET;
            fg_ptr         = '0;
            bg_ptr         = '0;
            fg_grants      = '0;
            bg_grants      = '0;
            mismatch_count = 0;
            grant_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                weight = cfg_wdata;
            // Retire the result first: it always belongs to an earlier round.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.valid = m_axis_tdata[0];
                got.slot  = m_axis_tdata[6:1];
                got.bg    = m_axis_tuser;
                if (grant_q.size() == 0)
                begin
                    $display("%0t: unexpected grant result: expected none, actual valid=%0d "
                             , $time, got.valid, "slot=%0d background=%0d", got.slot, got.bg);
                    mismatch_count++;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (got.valid !== want.valid)
                        report("grant_valid", want.valid, got.valid);
                    if (got.slot !== want.slot)
                        report("grant_slot", want.slot, got.slot);
                    if (got.bg !== want.bg)
                        report("grant_background", want.bg, got.bg);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                grant_q.push_back(pick_slot(s_axis_tdata[63:0], s_axis_tdata[127:64]));
            errors  <= mismatch_count;
            pending <= grant_q.size();
        end
    end

endmodule

[sim/testbench.sv]
// Top of the picker testbench: clock, reset, weight writes, round stimulus and the verdict.
// Depends on twrr_pkg, twrr_grant_checker and two_class_weighted_round_robin_picker_core.
`timescale 1ns / 1ps

module testbench;

    localparam int ROUNDS_PER_PHASE = 140;
    localparam int HOLD_CYCLES      = 500;   // long result stall that backs up the block
    localparam int DRAIN_CYCLES     = 200;   // wait after the last grant for stray results
    localparam int WATCHDOG_LIMIT   = 4000;  // cycles with no transaction on either channel
    localparam logic [63:0] ALL_SLOTS = '1;
    localparam logic [63:0] ODD_SLOTS = 64'hAAAA_AAAA_AAAA_AAAA;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          cfg_we        = 1'b0;
    logic [twrr_pkg::WEIGHT_W-1:0] cfg_wdata     = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [127:0]                  s_axis_tdata  = '0; // [63:0] runnable, [127:64] background
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [7:0]                    m_axis_tdata;  // [0] grant_valid, [6:1] grant_slot, [7] zero
    logic                          m_axis_tuser;  // [0] grant_background

    bit          src_gaps  = 1'b1;   // sender idles at random
    bit          sink_gaps = 1'b1;   // receiver stalls at random
    bit          hold_req  = 1'b0;   // ask the receiver for one long stall
    int          rounds_sent     = 0;
    int          weight_settings = 1;
    int          idle_cycles     = 0;
    int          err_count;
    int          pending;
    logic [63:0] last_run = '0;
    logic [63:0] last_bg  = '0;

    two_class_weighted_round_robin_picker_core #(
        .SLOTS(64)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    twrr_grant_checker #(
        .SLOTS(64)
    ) grant_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (err_count),
        .pending       (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog: end the run if neither channel moves a transaction for too long.
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired with %0d grants outstanding", $time, pending);
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: drop tready at random, or hold it low for a long stretch on request
    // so the output register fills, the block stalls its input and the sender waits.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                m_axis_tready <= !(sink_gaps && $urandom_range(99) < 22);
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Offer one round and hold it until the block takes it. Entered and left at a
    // falling edge, so tvalid stays high across back-to-back rounds.
    task automatic send_round(input logic [63:0] run, input logic [63:0] bg);
        while (src_gaps && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bg, run};
        last_run = run;
        last_bg  = bg;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        rounds_sent++;
        @(negedge clk);
    endtask

    // Mix of round shapes. Repeating the previous masks walks the pointers through
    // a stable set and lets the weight ratio between the classes play out.
    task automatic send_random_round();
        logic [63:0] run;
        logic [63:0] bg;
        logic [63:0] one;
        int          kind;
        kind = $urandom_range(99);
        run  = rand_word();
        bg   = rand_word();
        one  = 64'd1 << $urandom_range(63);
        if (kind < 25)
        begin
            // full random masks
        end
        else if (kind < 50)
        begin
            run = last_run;
            bg  = last_bg;
        end
        else if (kind < 65)
            run = run & rand_word() & rand_word();     // a handful of runnable slots
        else if (kind < 73)
            bg = bg & ~run;                            // foreground only
        else if (kind < 81)
            bg = bg | run;                             // background only
        else if (kind < 88)
        begin
            run = run | one;                           // one foreground slot among many
            bg  = run & ~one;
        end
        else if (kind < 93)
            run = '0;                                  // nothing runnable
        else
            run = ALL_SLOTS;
        send_round(run, bg);
    endtask

    // Let every outstanding grant come back, then write the weight while idle.
    task automatic set_weight(input logic [twrr_pkg::WEIGHT_W-1:0] w);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we <= 1'b0;
        weight_settings++;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rounds at the reset weight.
        send_round('0, '0);                      // nothing runnable
        send_round('0, ALL_SLOTS);               // nothing runnable, all marked background
        send_round(ALL_SLOTS, '0);               // all foreground: slot 0
        send_round(ALL_SLOTS, '0);               // pointer advances: slot 1
        send_round(ALL_SLOTS, ALL_SLOTS);        // all background
        send_round(64'd1 << 63, '0);             // top slot, foreground
        send_round(64'd1 << 63, 64'd1 << 63);    // top slot, background
        send_round(64'd1, ALL_SLOTS);            // bottom slot, background
        send_round(64'h3, 64'h2);                // one of each class
        send_round(64'h3, 64'h2);
        repeat (12) send_round(ALL_SLOTS, ODD_SLOTS);   // weight ratio between the classes
        repeat (ROUNDS_PER_PHASE - 20) send_random_round();

        // Smallest nonzero weight.
        set_weight(8'd1);
        repeat (ROUNDS_PER_PHASE) send_random_round();

        // Largest weight, with no idling on either side.
        set_weight(8'd255);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        repeat (ROUNDS_PER_PHASE) send_random_round();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;

        // Zero weight: foreground wins only when background is empty.
        set_weight(8'd0);
        repeat (ROUNDS_PER_PHASE) send_random_round();

        // Random weight, with a long result stall in the middle.
        set_weight(8'($urandom_range(254, 2)));
        repeat (20) send_random_round();
        hold_req = 1'b1;
        repeat (ROUNDS_PER_PHASE - 20) send_random_round();

        // Back to the reset value.
        set_weight(twrr_pkg::WEIGHT_RESET);
        repeat (ROUNDS_PER_PHASE) send_random_round();

        // Drain: wait for the last grants, then give the block time to show strays.
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d scheduling rounds over %0d weight settings (0, 1, 255 among them),",
                 rounds_sent, weight_settings);
        $display("with random idling on both sides and one %0d-cycle result stall.",
                 HOLD_CYCLES);
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/twrr_pkg.sv
sv/twrr_mod_unit.sv
sv/two_class_weighted_round_robin_picker_core.sv
sim/twrr_grant_checker.sv
sim/testbench.sv
